// ===== rtl/sba_pkg.sv =====
// shared types, codes and field widths of the sector bitmap allocator
package sba_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned SECTOR_W = 12;
  localparam int unsigned BOUND_W  = 13;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SET_RANGE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLR_RANGE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TEST_BIT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ALLOC_META = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BEST_FIT   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_META_START   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DATA_START   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SECTOR_LIMIT = 2'd2;

  localparam logic [SECTOR_W-1:0] META_START_RST   = 12'd1;
  localparam logic [BOUND_W-1:0]  DATA_START_RST   = 13'd256;
  localparam logic [BOUND_W-1:0]  SECTOR_LIMIT_RST = 13'd4096;

  // request payload, last field in the lowest bits
  typedef struct packed {
    logic [6:0]          pad;
    logic [BOUND_W-1:0]  min_run_len;
    logic [BOUND_W-1:0]  end_sector;
    logic [SECTOR_W-1:0] first_sector;
    logic [CMD_W-1:0]    cmd;
  } sba_req_t;

  // result payload, last field in the lowest bits
  typedef struct packed {
    logic                pad;
    logic                bit_value;
    logic [SECTOR_W-1:0] found_sector;
    logic [STATUS_W-1:0] status;
  } sba_res_t;

  localparam int unsigned REQ_TDATA_W = $bits(sba_req_t);
  localparam int unsigned RES_TDATA_W = $bits(sba_res_t);

endpackage

// ===== rtl/sba_ram.sv =====
// generic single write port ram with registered read
module sba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sector_bitmap_allocator.sv =====
// sector bitmap allocator: used/free map, range update, test, meta alloc, best fit
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   cmd, first_sector, end_sector, min_run_len
//  m_axis    out  m_axis_tvalid/m_axis_tready   status, found_sector, bit_value
//  cfg       in   cfg_we_i                      cfg_addr_i, cfg_wdata_i
//
// a request scans the bitmap ram one word a cycle through one word-wide find-first unit,
// except that best fit scans the same word again whenever a free run opens in it or is
// ended by a used sector in it; test reads a single word.
// after reset a clearing pass zeroes every ram word; no request is taken until it ends.
// a result waiting on m_axis does not stop the next request from being taken.
module sector_bitmap_allocator #(
  parameter int unsigned NUM_SECTORS = 4096,  // power of two
  parameter int unsigned WORD_BITS   = 32     // power of two
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cmd, first_sector, end_sector, min_run_len, zero pad
  input  logic [sba_pkg::REQ_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // status, found_sector, bit_value, zero pad
  output logic [sba_pkg::RES_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [sba_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [sba_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  import sba_pkg::*;

  localparam int unsigned NUM_WORDS = NUM_SECTORS / WORD_BITS;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned OW        = $clog2(WORD_BITS);
  localparam int unsigned SEC_W     = $clog2(NUM_SECTORS) + 1;
  localparam int unsigned CW        = (SEC_W > BOUND_W) ? SEC_W : BOUND_W;
  localparam logic [CW-1:0] NUM_C   = CW'(NUM_SECTORS);
  localparam logic [CW-1:0] WORD_C  = CW'(WORD_BITS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_OP    = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  sba_req_t req;
  assign req = sba_req_t'(s_axis_tdata);

  logic [SECTOR_W-1:0] meta_start_q;
  logic [BOUND_W-1:0]  data_start_q, sector_limit_q;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       pos_q, pos_d;
  logic                in_run_q, in_run_d;
  logic                best_found_q, best_found_d;
  logic                m_tvalid_q, m_tvalid_d;
  logic [CW-1:0]       lim_q, lim_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [BOUND_W-1:0]  need_q, need_d;
  logic [CW-1:0]       run_start_q, run_start_d;
  logic [CW-1:0]       best_len_q, best_len_d;
  logic [CW-1:0]       best_at_q, best_at_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [CW-1:0]       res_index_q, res_index_d;
  logic                res_bit_q, res_bit_d;
  sba_res_t            m_tdata_q, m_tdata_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  sba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // {found, index} of lowest set bit
  function automatic logic [OW:0] find_first(input logic [WORD_BITS-1:0] v);
    logic [OW:0] r;
    r = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        r = {1'b1, OW'(b)};
      end
    end
    return r;
  endfunction

  // word datapath: in-range mask and the shared find-first unit
  logic [CW-1:0]        base, next_base;
  logic [WORD_BITS-1:0] mask;
  logic                 last_word;
  logic [OW:0]          scan_hit;
  logic [CW-1:0]        hit_sec;
  logic [CW-1:0]        run_end, run_len;
  logic                 take;

  always_comb begin
    base      = {pos_q[CW-1:OW], {OW{1'b0}}};
    next_base = base + WORD_C;
    last_word = (next_base >= lim_q);
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (OW'(b) >= pos_q[OW-1:0]) && ((base + CW'(b)) < lim_q);
    end
    // free bits while no run is open, used bits inside a run
    scan_hit = find_first((in_run_q ? ram_rdata : ~ram_rdata) & mask);
    hit_sec  = base + CW'(scan_hit[OW-1:0]);
    run_end  = scan_hit[OW] ? hit_sec : lim_q;
    run_len  = run_end - run_start_q;
    take     = (run_len >= CW'(need_q)) && (!best_found_q || (best_len_q > run_len));
  end

  logic [CW-1:0]  start_pos, start_lim;
  logic           start_go;
  logic [CW-1:0]  first_c, end_c, meta_c, data_c, limit_c;
  logic           fit_found;
  logic [CW-1:0]  fit_at;

  always_comb begin
    first_c = CW'(req.first_sector);
    end_c   = CW'(req.end_sector);
    meta_c  = CW'(meta_start_q);
    data_c  = CW'(data_start_q);
    limit_c = CW'(sector_limit_q);

    start_go  = 1'b0;
    start_pos = first_c;
    start_lim = end_c;

    fit_found = best_found_q | (in_run_q & take);
    fit_at    = (in_run_q & take) ? run_start_q : best_at_q;

    state_d      = state_q;
    pos_d        = pos_q;
    in_run_d     = in_run_q;
    best_found_d = best_found_q;
    lim_d        = lim_q;
    cmd_d        = cmd_q;
    need_d       = need_q;
    run_start_d  = run_start_q;
    best_len_d   = best_len_q;
    best_at_d    = best_at_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_bit_d    = res_bit_q;
    m_tdata_d    = m_tdata_q;
    m_tvalid_d   = m_tvalid_q & ~m_axis_tready;

    ram_we    = 1'b0;
    ram_waddr = pos_q[OW +: AW];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = next_base[OW +: AW];

    s_axis_tready = (state_q == S_IDLE);

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        pos_d  = next_base;
        if (next_base >= NUM_C) begin
          pos_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d        = req.cmd;
          need_d       = req.min_run_len;
          in_run_d     = 1'b0;
          best_found_d = 1'b0;
          res_status_d = ST_OK;
          res_index_d  = '0;
          res_bit_d    = 1'b0;
          case (req.cmd)
            CMD_SET_RANGE, CMD_CLR_RANGE: begin
              if (first_c < end_c) begin
                if (end_c > NUM_C) begin
                  res_status_d = ST_BAD_IDX;
                end else begin
                  start_go = 1'b1;
                end
              end
            end
            CMD_TEST_BIT: begin
              start_lim = first_c + CW'(1);
              if (first_c >= NUM_C) begin
                res_status_d = ST_BAD_IDX;
              end else begin
                start_go = 1'b1;
              end
            end
            CMD_ALLOC_META: begin
              start_pos = meta_c;
              start_lim = data_c;
              if (meta_c < data_c && data_c > NUM_C) begin
                res_status_d = ST_BAD_IDX;
              end else if (meta_c < data_c) begin
                start_go = 1'b1;
              end else begin
                res_status_d = ST_NONE;
              end
            end
            CMD_BEST_FIT: begin
              start_pos = data_c;
              start_lim = limit_c;
              if (data_c < limit_c && limit_c > NUM_C) begin
                res_status_d = ST_BAD_IDX;
              end else if (data_c < limit_c) begin
                start_go = 1'b1;
              end else begin
                res_status_d = ST_NONE;
              end
            end
            default: begin
            end
          endcase
          if (start_go) begin
            pos_d     = start_pos;
            lim_d     = start_lim;
            ram_re    = 1'b1;
            ram_raddr = start_pos[OW +: AW];
            state_d   = S_OP;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_OP: begin
        case (cmd_q)
          CMD_SET_RANGE, CMD_CLR_RANGE: begin
            ram_we    = 1'b1;
            ram_wdata = (cmd_q == CMD_SET_RANGE) ? (ram_rdata | mask) : (ram_rdata & ~mask);
            if (last_word) begin
              state_d = S_DONE;
            end else begin
              pos_d  = next_base;
              ram_re = 1'b1;
            end
          end
          CMD_TEST_BIT: begin
            res_bit_d = ram_rdata[pos_q[OW-1:0]];
            state_d   = S_DONE;
          end
          CMD_ALLOC_META: begin
            if (scan_hit[OW]) begin
              ram_we      = 1'b1;
              ram_wdata   = ram_rdata | (WORD_BITS'(1) << scan_hit[OW-1:0]);
              res_index_d = hit_sec;
              state_d     = S_DONE;
            end else if (last_word) begin
              res_status_d = ST_NONE;
              state_d      = S_DONE;
            end else begin
              pos_d  = next_base;
              ram_re = 1'b1;
            end
          end
          CMD_BEST_FIT: begin
            if (!in_run_q && scan_hit[OW]) begin
              // run opens, look for its end in the same word next cycle
              in_run_d    = 1'b1;
              run_start_d = hit_sec;
              pos_d       = hit_sec;
            end else if (in_run_q && scan_hit[OW]) begin
              in_run_d     = 1'b0;
              pos_d        = hit_sec;
              best_found_d = fit_found;
              best_at_d    = fit_at;
              if (take) begin
                best_len_d = run_len;
              end
            end else if (last_word) begin
              // an open run is closed by the search limit
              res_status_d = fit_found ? ST_OK : ST_NONE;
              res_index_d  = fit_found ? fit_at : '0;
              state_d      = S_DONE;
            end else begin
              pos_d  = next_base;
              ram_re = 1'b1;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d             = 1'b1;
          m_tdata_d.pad          = 1'b0;
          m_tdata_d.bit_value    = res_bit_q;
          m_tdata_d.found_sector = res_index_q[SECTOR_W-1:0];
          m_tdata_d.status       = res_status_q;
          state_d                = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      pos_q          <= '0;
      in_run_q       <= 1'b0;
      best_found_q   <= 1'b0;
      m_tvalid_q     <= 1'b0;
      meta_start_q   <= META_START_RST;
      data_start_q   <= DATA_START_RST;
      sector_limit_q <= SECTOR_LIMIT_RST;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      in_run_q     <= in_run_d;
      best_found_q <= best_found_d;
      m_tvalid_q   <= m_tvalid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_META_START:   meta_start_q   <= cfg_wdata_i[SECTOR_W-1:0];
          REG_DATA_START:   data_start_q   <= cfg_wdata_i;
          REG_SECTOR_LIMIT: sector_limit_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q        <= lim_d;
    cmd_q        <= cmd_d;
    need_q       <= need_d;
    run_start_q  <= run_start_d;
    best_len_q   <= best_len_d;
    best_at_q    <= best_at_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_bit_q    <= res_bit_d;
    m_tdata_q    <= m_tdata_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule
